// ===== rtl/stg_pkg.sv =====
`timescale 1ns / 1ps
package stg_pkg;

  localparam int unsigned NPT_W      = 20;
  localparam int unsigned OUT_PER_W  = 27;
  localparam int unsigned HZ_W       = 11;
  localparam int unsigned DIVIDEND_W = 26;
  localparam int unsigned QUO_W      = 20;
  localparam int unsigned RATE_SHIFT = 7;
  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned RES_DEPTH  = 2;

  localparam logic [4:0]            SOUND_TYPE = 5'h12;
  localparam logic [2:0]            CODE_BELL  = 3'd1;
  localparam logic [2:0]            CODE_TONE  = 3'd2;
  localparam logic [DIVIDEND_W-1:0] RATE_CONST = 26'd37120000;
  localparam logic signed [31:0]    HZ_LOW     = 32'sd50;
  localparam logic signed [31:0]    HZ_HIGH    = 32'sd1050;
  localparam logic [HZ_W-1:0]       BELL_HZ    = 11'd1000;
  localparam logic [NPT_W-1:0]      NPT_RESET  = 20'd1000;

  typedef struct packed {
    logic               opcode;
    logic [4:0]         event_type;
    logic [2:0]         event_code;
    logic signed [31:0] tone_hz;
  } stg_in_t;

  typedef struct packed {
    logic                 status;
    logic                 step_pulse;
    logic                 dir_level;
    logic                 running;
    logic [OUT_PER_W-1:0] period_ns;
  } stg_out_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_REJECT,
    CMD_STOP,
    CMD_START
  } stg_cmd_kind_e;

  typedef struct packed {
    stg_cmd_kind_e   kind;
    logic [HZ_W-1:0] hz;
  } stg_cmd_t;

  typedef enum logic {
    BK_RUN,
    BK_DIV
  } stg_back_state_e;

  typedef struct packed {
    logic dividing;
    logic cmd_pop;
  } stg_back_stat_t;

endpackage

// ===== rtl/stg_fifo.sv =====
`timescale 1ns / 1ps
module stg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/stg_front.sv =====
`timescale 1ns / 1ps
module stg_front (
  input  stg_pkg::stg_in_t  req_i,
  output stg_pkg::stg_cmd_t cmd_o
);
  import stg_pkg::*;

  logic hz_in_range;

  assign hz_in_range = (req_i.tone_hz > HZ_LOW) && (req_i.tone_hz < HZ_HIGH);

  always_comb begin
    cmd_o.kind = CMD_REJECT;
    cmd_o.hz   = req_i.tone_hz[HZ_W-1:0];
    if (req_i.opcode) begin
      cmd_o.kind = CMD_TICK;
    end else if (req_i.event_type == SOUND_TYPE) begin
      case (req_i.event_code)
        CODE_BELL: begin
          cmd_o.hz   = BELL_HZ;
          cmd_o.kind = (req_i.tone_hz != '0) ? CMD_START : CMD_STOP;
        end
        CODE_TONE: begin
          cmd_o.kind = hz_in_range ? CMD_START : CMD_STOP;
        end
        default: begin
          cmd_o.kind = CMD_REJECT;
        end
      endcase
    end
  end

endmodule

// ===== rtl/stg_div.sv =====
`timescale 1ns / 1ps
module stg_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [stg_pkg::HZ_W-1:0]   divisor_i,
  output logic                       valid_o,
  output logic [stg_pkg::QUO_W-1:0]  quo_o
);
  import stg_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic [HZ_W-1:0]       dvs_q;
  logic [HZ_W-1:0]       rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q, valid_q;
  logic [HZ_W:0]         trial, trial_sub;
  logic                  ge;

  assign trial     = {rem_q, quo_q[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign ge        = (trial >= {1'b0, dvs_q});
  assign valid_o   = valid_q;
  assign quo_o     = quo_q[QUO_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      valid_q <= 1'b0;
      cnt_q   <= CNT_W'(DIVIDEND_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q  <= 1'b0;
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= RATE_CONST;
    end else if (busy_q) begin
      rem_q <= ge ? trial_sub[HZ_W-1:0] : trial[HZ_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/stg_back.sv =====
`timescale 1ns / 1ps
module stg_back #(
  parameter int unsigned PERIOD_WIDTH = 27
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [stg_pkg::NPT_W-1:0]   ns_per_tick_i,
  input  stg_pkg::stg_cmd_t           cmd_i,
  input  logic                        cmd_valid_i,
  input  logic                        res_full_i,
  output logic                        res_push_o,
  output stg_pkg::stg_out_t           res_o,
  output stg_pkg::stg_back_stat_t     stat_o
);
  import stg_pkg::*;

  localparam int unsigned RW = PERIOD_WIDTH + 1;

  stg_back_state_e       state_q, state_d;
  logic                  active_q, active_d;
  logic [PERIOD_WIDTH-1:0] interval_q, interval_d;
  logic [RW-1:0]         remain_q, remain_d;
  logic                  dir_q, dir_d;
  logic                  div_start, div_valid;
  logic [QUO_W-1:0]      quo;
  logic [RW:0]           left, reload;
  logic                  fire;
  logic                  cmd_pop, status, step;
  logic [OUT_PER_W-1:0]  new_period;

  stg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (cmd_i.hz),
    .valid_o   (div_valid),
    .quo_o     (quo)
  );

  assign left       = {1'b0, remain_q} - (RW + 1)'(ns_per_tick_i);
  assign fire       = left[RW] | (left == '0);
  assign reload     = left + (RW + 1)'(interval_q);
  assign new_period = {quo, {RATE_SHIFT{1'b0}}};

  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    interval_d = interval_q;
    remain_d   = remain_q;
    dir_d      = dir_q;
    div_start  = 1'b0;
    cmd_pop    = 1'b0;
    res_push_o = 1'b0;
    status     = 1'b0;
    step       = 1'b0;
    case (state_q)
      BK_RUN: begin
        if (cmd_valid_i && !res_full_i) begin
          case (cmd_i.kind)
            CMD_TICK: begin
              cmd_pop    = 1'b1;
              res_push_o = 1'b1;
              if (active_q) begin
                if (fire) begin
                  step     = 1'b1;
                  dir_d    = ~dir_q;
                  remain_d = reload[RW] ? '0 : reload[RW-1:0];
                end else begin
                  remain_d = left[RW-1:0];
                end
              end
            end
            CMD_REJECT: begin
              cmd_pop    = 1'b1;
              res_push_o = 1'b1;
              status     = 1'b1;
            end
            CMD_STOP: begin
              cmd_pop    = 1'b1;
              res_push_o = 1'b1;
              active_d   = 1'b0;
            end
            CMD_START: begin
              active_d  = 1'b0;
              div_start = 1'b1;
              state_d   = BK_DIV;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      BK_DIV: begin
        if (div_valid && !res_full_i) begin
          interval_d = PERIOD_WIDTH'(new_period);
          remain_d   = RW'(new_period);
          active_d   = 1'b1;
          cmd_pop    = 1'b1;
          res_push_o = 1'b1;
          state_d    = BK_RUN;
        end
      end
      default: begin
        state_d = BK_RUN;
      end
    endcase
  end

  assign res_o.status     = status;
  assign res_o.step_pulse = step;
  assign res_o.dir_level  = dir_d;
  assign res_o.running    = active_d;
  assign res_o.period_ns  = interval_d[OUT_PER_W-1:0];

  assign stat_o.dividing = (state_q == BK_DIV);
  assign stat_o.cmd_pop  = cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_RUN;
      active_q   <= 1'b0;
      interval_q <= '0;
      remain_q   <= '0;
      dir_q      <= 1'b1;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      interval_q <= interval_d;
      remain_q   <= remain_d;
      dir_q      <= dir_d;
    end
  end

endmodule

// ===== rtl/stepper_tone_generator_core.sv =====
`timescale 1ns / 1ps
// Stepper tone generator: drives the step and direction lines of a drive
// stepper so that it sounds a tone.
// Request side is a queue: present req_i and raise push; the request is
// taken at an edge where push is high and full is low. Each request is a
// time tick (opcode 1) or a sound event (opcode 0).
// Result side is a queue: while empty is low, rsp_o holds the oldest result;
// raise pop to take it. Every request yields exactly one result, in order.
// Ticks, rejected and stopping events: the result is written to the result
// queue from the request queue head; one request per cycle sustained while
// the result queue has room and no divide runs. Starting events run a
// restoring divider for the period, one quotient bit per cycle; their result
// shows once the division is done, and following requests queue behind it.
// A 2-entry request queue and a 2-entry result queue decouple both sides;
// when pop stays low the result queue fills, the executor halts, and full
// rises once the request queue is full. No result is dropped.
// Reset: timer stopped, period 0, direction level high, ns_per_tick 1000.
// cfg_we_i/cfg_wdata_i load ns_per_tick; write it only while idle.
module stepper_tone_generator_core #(
  parameter int unsigned PERIOD_WIDTH = 27
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  input  stg_pkg::stg_in_t           req_i,
  output logic                       full,
  input  logic                       pop,
  output stg_pkg::stg_out_t          rsp_o,
  output logic                       empty,
  input  logic                       cfg_we_i,
  input  logic [stg_pkg::NPT_W-1:0]  cfg_wdata_i
);
  import stg_pkg::*;

  logic [NPT_W-1:0]          npt_q;
  stg_cmd_t                  cmd_new, cmd_head;
  logic [$bits(stg_cmd_t)-1:0] cmd_data;
  logic                      cmd_empty;
  logic                      res_push, res_full;
  stg_out_t                  res_new;
  logic [$bits(stg_out_t)-1:0] res_data;
  stg_back_stat_t            back_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      npt_q <= NPT_RESET;
    end else if (cfg_we_i) begin
      npt_q <= cfg_wdata_i;
    end
  end

  stg_front u_front (
    .req_i (req_i),
    .cmd_o (cmd_new)
  );

  stg_fifo #(
    .WIDTH ($bits(stg_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_new),
    .full_o  (full),
    .pop_i   (back_stat.cmd_pop),
    .data_o  (cmd_data),
    .empty_o (cmd_empty)
  );

  assign cmd_head = stg_cmd_t'(cmd_data);

  stg_back #(
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ns_per_tick_i (npt_q),
    .cmd_i         (cmd_head),
    .cmd_valid_i   (~cmd_empty),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (res_new),
    .stat_o        (back_stat)
  );

  stg_fifo #(
    .WIDTH ($bits(stg_out_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_new),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_data),
    .empty_o (empty)
  );

  assign rsp_o = stg_out_t'(res_data);

`ifndef SYNTH
  a_running_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.running) |-> (rsp_o.period_ns != '0))
    else $error("running result with zero period");

  a_reject_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.status) |-> !rsp_o.step_pulse)
    else $error("rejected event reports a step pulse");

  a_div_holds_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.dividing |-> !cmd_empty)
    else $error("divider busy without its request queued");

  a_pop_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.cmd_pop |-> (res_push && !res_full && !cmd_empty))
    else $error("request retired without a result");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import stg_pkg::*;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [NPT_W-1:0] EXACT_NS = 20'd566176;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  stg_in_t req_i = '0;
  logic full;
  logic pop = 1'b0;
  stg_out_t rsp_o;
  logic empty;
  logic cfg_we_i = 1'b0;
  logic [NPT_W-1:0] cfg_wdata_i = '0;

  stg_in_t sound_tick_queue[$];
  stg_out_t step_results_due[$];

  logic tone_on = 1'b0;
  logic [OUT_PER_W-1:0] half_period = '0;
  logic [OUT_PER_W:0] time_left = '0;
  logic dir_toggle = 1'b1;
  logic dir_out = 1'b1;
  logic [NPT_W-1:0] tick_ns = NPT_RESET;

  int unsigned push_gap = 0;
  int unsigned pop_gap = 0;
  int unsigned pop_wait;
  logic send_calm = 1'b0;
  logic take_calm = 1'b0;
  int quiet_cycles = 0;
  int n_err = 0;
  int n_req = 0;
  int n_res = 0;
  int n_pulse = 0;
  int n_reject = 0;
  int n_cfg = 0;

  stepper_tone_generator_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .req_i      (req_i),
    .full       (full),
    .pop        (pop),
    .rsp_o      (rsp_o),
    .empty      (empty),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic stg_out_t next_step_result(input stg_in_t rq);
    stg_out_t res;
    longint left;
    longint hz;
    longint half;
    res = '0;
    if (rq.opcode == OP_TICK) begin
      if (tone_on) begin
        left = longint'(time_left) - longint'(tick_ns);
        if (left > 0) begin
          time_left = left[OUT_PER_W:0];
        end else begin
          dir_out = !dir_toggle;
          dir_toggle = !dir_toggle;
          left = left + longint'(half_period);
          if (left < 0) left = 0;
          time_left = left[OUT_PER_W:0];
          res.step_pulse = 1'b1;
        end
      end
    end else if (rq.event_type != SOUND_TYPE ||
                 (rq.event_code != CODE_BELL && rq.event_code != CODE_TONE)) begin
      res.status = 1'b1;
    end else begin
      hz = longint'($signed(rq.tone_hz));
      if (rq.event_code == CODE_BELL && hz != 0) hz = longint'(BELL_HZ);
      tone_on = 1'b0;
      if (hz > longint'(HZ_LOW) && hz < longint'(HZ_HIGH)) begin
        half = (longint'(RATE_CONST) / hz) << RATE_SHIFT;
        half_period = half[OUT_PER_W-1:0];
        if (half_period != '0) begin
          time_left = {1'b0, half_period};
          tone_on = 1'b1;
        end
      end
    end
    res.dir_level = dir_out;
    res.running = tone_on;
    res.period_ns = half_period;
    return res;
  endfunction

  function automatic stg_in_t sound_event(input logic [4:0] ty, input logic [2:0] code,
                                          input logic [31:0] hz);
    stg_in_t it;
    it.opcode = OP_EVENT;
    it.event_type = ty;
    it.event_code = code;
    it.tone_hz = hz;
    return it;
  endfunction

  function automatic stg_in_t tick_item();
    stg_in_t it;
    it.opcode = OP_TICK;
    it.event_type = 5'($urandom_range(0, 31));
    it.event_code = 3'($urandom_range(0, 7));
    it.tone_hz = $urandom;
    return it;
  endfunction

  function automatic stg_in_t start_event();
    if ($urandom_range(0, 5) == 0) return sound_event(SOUND_TYPE, CODE_BELL, $urandom | 32'h1);
    if ($urandom_range(0, 1) == 0) return sound_event(SOUND_TYPE, CODE_TONE, $urandom_range(900, 1049));
    return sound_event(SOUND_TYPE, CODE_TONE, $urandom_range(51, 1049));
  endfunction

  function automatic stg_in_t odd_event();
    logic [4:0] ty;
    logic [2:0] code;
    case ($urandom_range(0, 5))
      0: begin
        ty = 5'($urandom_range(0, 30));
        if (ty >= SOUND_TYPE) ty = ty + 5'd1;
        return sound_event(ty, CODE_TONE, $urandom);
      end
      1: begin
        code = 3'($urandom_range(3, 8));
        return sound_event(SOUND_TYPE, code, $urandom);
      end
      2: return sound_event(SOUND_TYPE, CODE_BELL, 32'd0);
      3: return sound_event(SOUND_TYPE, CODE_TONE, $urandom);
      4: begin
        case ($urandom_range(0, 3))
          0: return sound_event(SOUND_TYPE, CODE_TONE, 32'd50);
          1: return sound_event(SOUND_TYPE, CODE_TONE, 32'd1050);
          2: return sound_event(SOUND_TYPE, CODE_TONE, 32'd0);
          default: return sound_event(SOUND_TYPE, CODE_TONE, -32'sd5);
        endcase
      end
      default: return sound_event(SOUND_TYPE, CODE_TONE, $urandom_range(1050, 100000));
    endcase
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    n_err++;
  endtask

  task automatic check_step_result(input stg_out_t got);
    stg_out_t want;
    if (step_results_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      n_err++;
      return;
    end
    want = step_results_due.pop_front();
    n_res++;
    n_pulse += want.step_pulse;
    n_reject += want.status;
    if (got.status !== want.status) report_field("status", want.status, got.status);
    if (got.step_pulse !== want.step_pulse)
      report_field("step_pulse", want.step_pulse, got.step_pulse);
    if (got.dir_level !== want.dir_level)
      report_field("dir_level", want.dir_level, got.dir_level);
    if (got.running !== want.running) report_field("running", want.running, got.running);
    if (got.period_ns !== want.period_ns)
      report_field("period_ns", want.period_ns, got.period_ns);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      req_i <= '0;
      push_gap <= 0;
    end else begin
      if (push && !full) begin
        step_results_due.push_back(next_step_result(req_i));
        n_req++;
      end
      if (!(push && full)) begin
        if (push_gap != 0) begin
          push <= 1'b0;
          push_gap <= push_gap - 1;
        end else if (sound_tick_queue.size() != 0) begin
          req_i <= sound_tick_queue.pop_front();
          push <= 1'b1;
          push_gap <= send_calm ? 0 : $urandom_range(0, 3);
          if ($urandom_range(0, 63) == 0) send_calm <= !send_calm;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      pop_gap <= 0;
    end else begin
      pop_wait = pop_gap;
      if (pop && !empty) begin
        check_step_result(rsp_o);
        pop_wait = take_calm ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 63) == 0) take_calm <= !take_calm;
      end
      if (pop_wait != 0) begin
        pop <= 1'b0;
        pop_gap <= pop_wait - 1;
      end else begin
        pop <= 1'b1;
        pop_gap <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[stepper_tone_generator_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (sound_tick_queue.size() != 0 || push || step_results_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_tick_ns(input logic [NPT_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tick_ns = v;
    n_cfg++;
  endtask

  task automatic load_directed();
    stg_in_t it;
    it = '1;
    sound_tick_queue.push_back(it);
    it = '0;
    it.opcode = OP_TICK;
    sound_tick_queue.push_back(it);
    sound_tick_queue.push_back(sound_event(5'd0, CODE_TONE, 32'd440));
    sound_tick_queue.push_back(sound_event(5'd31, CODE_TONE, 32'd440));
    for (int c = 0; c < 8; c++)
      if (c != CODE_BELL && c != CODE_TONE)
        sound_tick_queue.push_back(sound_event(SOUND_TYPE, 3'(c), 32'd440));
    sound_tick_queue.push_back(sound_event(SOUND_TYPE, CODE_TONE, 32'd440));
    sound_tick_queue.push_back(tick_item());
    sound_tick_queue.push_back(sound_event(SOUND_TYPE, CODE_TONE, 32'd50));
    sound_tick_queue.push_back(sound_event(SOUND_TYPE, CODE_TONE, 32'd1050));
    sound_tick_queue.push_back(sound_event(SOUND_TYPE, CODE_TONE, 32'd51));
    sound_tick_queue.push_back(sound_event(SOUND_TYPE, CODE_TONE, 32'd1049));
    sound_tick_queue.push_back(sound_event(SOUND_TYPE, CODE_TONE, 32'd0));
    sound_tick_queue.push_back(sound_event(SOUND_TYPE, CODE_TONE, 32'h8000_0000));
    sound_tick_queue.push_back(sound_event(SOUND_TYPE, CODE_TONE, 32'h7FFF_FFFF));
    sound_tick_queue.push_back(sound_event(SOUND_TYPE, CODE_BELL, 32'd0));
    sound_tick_queue.push_back(sound_event(SOUND_TYPE, CODE_BELL, 32'hFFFF_FFFF));
    sound_tick_queue.push_back(tick_item());
    sound_tick_queue.push_back(sound_event(SOUND_TYPE, CODE_BELL, 32'd1));
    sound_tick_queue.push_back(tick_item());
  endtask

  task automatic add_songs(input int n);
    int added;
    int run;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 4) != 0) begin
        sound_tick_queue.push_back(start_event());
        run = $urandom_range(4, 60);
      end else begin
        sound_tick_queue.push_back(odd_event());
        run = $urandom_range(0, 5);
      end
      added += run + 1;
      repeat (run) sound_tick_queue.push_back(tick_item());
    end
  endtask

  initial begin
    logic [NPT_W-1:0] phase_ns [6];
    int phase_len [6];
    phase_ns = '{20'hFFFFF, EXACT_NS, 20'd1000000, 20'd0, 20'd1, 20'd0};
    phase_ns[5] = 20'($urandom_range(2000, 1048575));
    phase_len = '{380, 230, 330, 80, 80, 300};
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    load_directed();
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_tick_ns(phase_ns[p]);
      @(negedge clk_i);
      if (phase_ns[p] == EXACT_NS) begin
        // land exactly on expiry: eight ticks per half period at 1049 Hz
        sound_tick_queue.push_back(sound_event(SOUND_TYPE, CODE_TONE, 32'd1049));
        repeat (24) sound_tick_queue.push_back(tick_item());
      end
      add_songs(phase_len[p]);
    end
    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Run covered %0d requests and %0d checked results under %0d tick lengths.",
             n_req, n_res, n_cfg + 1);
    $display("Step pulses seen: %0d, rejected sound events: %0d.", n_pulse, n_reject);
    if (n_err == 0) begin
      $display("[stepper_tone_generator_core] OK");
    end else begin
      $display("[stepper_tone_generator_core] ERROR");
    end
    $finish;
  end

endmodule
